### hw/rtl/parity_select_stack_top_defines.svh
// ----------------------------------------------------------------------------
// parity_select_stack_top_defines.svh
// Assertion macros shared by the stack RTL.
// ----------------------------------------------------------------------------
`ifndef PARITY_SELECT_STACK_TOP_DEFINES_SVH
`define PARITY_SELECT_STACK_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("parity_select_stack: check failed");

// Next-cycle implication, disabled while reset is held.
`define PSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("parity_select_stack: check failed");

`endif

### hw/rtl/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Types and codes for the parity select stack.
// ----------------------------------------------------------------------------
package pss_pkg;

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_ODD  = 2'd2,
        ACT_EVEN = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_NOMATCH = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_TOP,
        S_DONE
    } t_state;

    localparam int unsigned OUT_WIDTH   = 32;
    localparam int unsigned COUNT_WIDTH = 5;

    typedef struct packed {
        t_status                 status;
        logic [OUT_WIDTH-1:0]    top_value;
        logic [COUNT_WIDTH-1:0]  count;
        logic                    is_empty;
    } t_result;

endpackage

### hw/rtl/pss_mem.sv
// ----------------------------------------------------------------------------
// pss_mem
// Stack word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pss_mem #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned WORD_WIDTH = 32,
    parameter int unsigned AW         = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [WORD_WIDTH-1:0] i_wdata,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr,
    output logic [WORD_WIDTH-1:0] o_rdata
);

    logic [WORD_WIDTH-1:0] r_mem [DEPTH];
    logic [WORD_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/pss_outreg.sv
// ----------------------------------------------------------------------------
// pss_outreg
// Result register between the sequencer and the downstream side.
// ----------------------------------------------------------------------------
module pss_outreg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  pss_pkg::t_result  i_res,
    input  logic              i_out_stall,
    output logic              o_free,
    output logic              o_out_valid,
    output logic [1:0]        o_status,
    output logic [31:0]       o_top_value,
    output logic [4:0]        o_count,
    output logic              o_is_empty
);

    import pss_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // slot free when empty or being drained this cycle
    assign o_free = !r_valid || !i_out_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_status    = r_res.status;
    assign o_top_value = r_res.top_value;
    assign o_count     = r_res.count;
    assign o_is_empty  = r_res.is_empty;

endmodule

### hw/rtl/pss_ctrl.sv
// ----------------------------------------------------------------------------
// pss_ctrl
// Sequencer: fill count, top word cache, parity scan and gap closing.
// ----------------------------------------------------------------------------
`include "parity_select_stack_top_defines.svh"

module pss_ctrl #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned WORD_WIDTH = 32,
    parameter int unsigned AW         = $clog2(DEPTH),
    parameter int unsigned CW         = $clog2(DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_action,
    input  logic signed [31:0]      i_value,
    output logic                    o_mem_we,
    output logic [AW-1:0]           o_mem_waddr,
    output logic [WORD_WIDTH-1:0]   o_mem_wdata,
    output logic                    o_mem_re,
    output logic [AW-1:0]           o_mem_raddr,
    input  logic [WORD_WIDTH-1:0]   i_mem_rdata,
    input  logic                    i_out_free,
    output logic                    o_res_load,
    output pss_pkg::t_result        o_res
);

    import pss_pkg::*;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [AW-1:0]         r_idx, n_idx;
    logic                  r_want, n_want;
    t_status               r_status, n_status;
    logic [WORD_WIDTH-1:0] r_top, n_top;

    logic                  w_accept;
    logic [WORD_WIDTH-1:0] w_push_word;
    logic [CW-1:0]         w_idx_ext;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_push_word = WORD_WIDTH'(i_value);
    assign w_idx_ext   = CW'(r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_want   <= n_want;
        r_status <= n_status;
        r_top    <= n_top;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_want      = r_want;
        n_status    = r_status;
        n_top       = r_top;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx;
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_idx;
        o_res_load  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status = ST_OK;
                    n_state  = S_DONE;
                    unique case (t_action'(i_action))
                        ACT_PUSH: begin
                            if (r_cnt == CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = r_cnt[AW-1:0];
                                o_mem_wdata = w_push_word;
                                n_cnt       = r_cnt + CW'(1);
                                n_top       = w_push_word;
                            end
                        end
                        ACT_POP: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_cnt = r_cnt - CW'(1);
                                if (r_cnt != CW'(1)) begin
                                    // fetch the word that becomes the top
                                    o_mem_re    = 1'b1;
                                    o_mem_raddr = AW'(r_cnt - CW'(2));
                                    n_state     = S_TOP;
                                end
                            end
                        end
                        ACT_ODD, ACT_EVEN: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = AW'(r_cnt - CW'(1));
                                n_idx       = AW'(r_cnt - CW'(1));
                                n_want      = (t_action'(i_action) == ACT_ODD);
                                n_state     = S_SCAN;
                            end
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // read data holds entry r_idx
                if (i_mem_rdata[0] == r_want) begin
                    if (w_idx_ext == r_cnt - CW'(1)) begin
                        // hit on the top: plain pop
                        n_cnt = r_cnt - CW'(1);
                        if (r_cnt == CW'(1)) begin
                            n_state = S_DONE;
                        end else begin
                            o_mem_re    = 1'b1;
                            o_mem_raddr = AW'(r_cnt - CW'(2));
                            n_state     = S_TOP;
                        end
                    end else begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = r_idx + AW'(1);
                        n_state     = S_SHIFT;
                    end
                end else if (r_idx == '0) begin
                    n_status = ST_NOMATCH;
                    n_state  = S_DONE;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_idx - AW'(1);
                    n_idx       = r_idx - AW'(1);
                end
            end

            S_SHIFT: begin
                // move entry r_idx+1 down into r_idx
                o_mem_we    = 1'b1;
                o_mem_waddr = r_idx;
                o_mem_wdata = i_mem_rdata;
                if (w_idx_ext + CW'(2) == r_cnt) begin
                    n_cnt   = r_cnt - CW'(1);
                    n_top   = i_mem_rdata;
                    n_state = S_DONE;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_idx + AW'(2);
                    n_idx       = r_idx + AW'(1);
                end
            end

            S_TOP: begin
                n_top   = i_mem_rdata;
                n_state = S_DONE;
            end

            S_DONE: begin
                o_res_load = i_out_free;
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res.status    = r_status;
    assign o_res.top_value = (r_cnt != '0) ? OUT_WIDTH'(signed'(r_top)) : '0;
    assign o_res.count     = COUNT_WIDTH'(r_cnt);
    assign o_res.is_empty  = (r_cnt == '0);

    `PSS_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(DEPTH))
    `PSS_ASSERT_IMP(a_we_state, i_clk, i_rst_n, o_mem_we, (r_state == S_IDLE) || (r_state == S_SHIFT))
    `PSS_ASSERT_IMP(a_scan_idx, i_clk, i_rst_n, r_state == S_SCAN, w_idx_ext < r_cnt)
    `PSS_ASSERT_IMP(a_shift_idx, i_clk, i_rst_n, r_state == S_SHIFT, w_idx_ext + CW'(1) < r_cnt)
    `PSS_ASSERT_NXT(a_load_idle, i_clk, i_rst_n, o_res_load, r_state == S_IDLE)

endmodule

### hw/rtl/parity_select_stack_top.sv
// ----------------------------------------------------------------------------
// parity_select_stack_top
// LIFO stack of signed words with removal of the latest odd or even word.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  input    | i_in_valid / o_in_stall   | i_action, i_value
//  output   | o_out_valid / i_out_stall | o_status, o_top_value, o_count,
//           |                           | o_is_empty
//
// One word in flight at a time. A push goes straight to its result; a pop
// reads the new top word from the store unless it empties the stack. A
// parity removal reads one entry per cycle downward from the top until a
// hit, then rewrites one entry per cycle above the hit, a pace set by the
// single read port of the word store. A hit on the top word of a deeper
// stack ends with a read that fetches the new top; a failed search reads
// every entry. Reset empties the stack at once: the fill count is cleared
// and the store itself is never swept. A result waiting in the output
// register does not block the next input word; only its completion waits.
//
module parity_select_stack_top #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned WORD_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_top_value,
    output logic [4:0]         o_count,
    output logic               o_is_empty
);

    import pss_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    // word store port
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [WORD_WIDTH-1:0] w_wdata;
    logic                  w_re;
    logic [AW-1:0]         w_raddr;
    logic [WORD_WIDTH-1:0] w_rdata;

    // sequencer to result register
    logic                  w_out_free;
    logic                  w_res_load;
    t_result               w_res;
    logic [31:0]           w_top_bits;

    pss_mem #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH),
        .AW         (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pss_ctrl #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_value     (i_value),
        .o_mem_we    (w_we),
        .o_mem_waddr (w_waddr),
        .o_mem_wdata (w_wdata),
        .o_mem_re    (w_re),
        .o_mem_raddr (w_raddr),
        .i_mem_rdata (w_rdata),
        .i_out_free  (w_out_free),
        .o_res_load  (w_res_load),
        .o_res       (w_res)
    );

    // output register parts the two handshakes
    pss_outreg u_outreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_res_load),
        .i_res       (w_res),
        .i_out_stall (i_out_stall),
        .o_free      (w_out_free),
        .o_out_valid (o_out_valid),
        .o_status    (o_status),
        .o_top_value (w_top_bits),
        .o_count     (o_count),
        .o_is_empty  (o_is_empty)
    );

    assign o_top_value = signed'(w_top_bits);

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for parity_select_stack_top.
//
// A directed table covers the empty stack, the word extremes, a removal from
// the middle of the stack, a full stack and a push that is dropped. Random
// episodes follow: push-heavy, drain-heavy or mixed, some of them with the
// parity of every word fixed. A shadow stack predicts each result, and every
// result is checked field by field in arrival order. Both sides idle in random
// bursts. The receiver holds off once for a long stretch, and the tail of the
// run has no idling.
// ----------------------------------------------------------------------------
module tb;

    import pss_pkg::*;

    localparam int STACK_DEPTH   = 16;
    localparam int RANDOM_ITEMS  = 380;
    localparam int CALM_ITEMS    = 60;      // tail of the run with no idling
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int DRAIN_CYCLES  = 64;      // margin for the last removal to finish
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DIRECTED_ROWS = 15;

    // One row of the directed table. Where has_check is set the result is
    // written out by hand; otherwise the shadow stack supplies it.
    typedef struct {
        t_action            act;
        logic signed [31:0] val;
        int                 reps;
        bit                 has_check;
        t_result            check;
    } t_stim_row;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_action     = '0;
    logic signed [31:0] i_value      = '0;
    logic               o_out_valid;
    logic               i_out_stall  = 1'b0;
    logic [1:0]         o_status;
    logic signed [31:0] o_top_value;
    logic [4:0]         o_count;
    logic               o_is_empty;

    // Travels alongside the payload so the monitor knows which result to queue.
    bit      stim_has_check = 1'b0;
    t_result stim_check     = '0;

    // Shadow copy of the stack.
    logic signed [31:0] shadow_words [STACK_DEPTH];
    int                 shadow_fill = 0;

    t_result pending_results [$];
    int      fail_count  = 0;
    int      cycle_count = 0;
    bit      calm        = 1'b0;    // set for the tail: no idling on either side
    bit      hold_req    = 1'b0;    // asks the receiver for one long hold-off

    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        // empty stack: every removal reports empty
        '{ACT_POP,  32'sd0,          1, 1'b1, '{ST_EMPTY,   32'h0000_0000, 5'd0,  1'b1}},
        '{ACT_ODD,  32'sd0,          1, 1'b1, '{ST_EMPTY,   32'h0000_0000, 5'd0,  1'b1}},
        '{ACT_EVEN, 32'sd0,          1, 1'b1, '{ST_EMPTY,   32'h0000_0000, 5'd0,  1'b1}},
        // largest word, then an even search that cannot hit
        '{ACT_PUSH, 32'sh7fff_ffff,  1, 1'b1, '{ST_OK,      32'h7fff_ffff, 5'd1,  1'b0}},
        '{ACT_EVEN, 32'sd0,          1, 1'b1, '{ST_NOMATCH, 32'h7fff_ffff, 5'd1,  1'b0}},
        // smallest word and negative words of both parities
        '{ACT_PUSH, 32'sh8000_0000,  1, 1'b1, '{ST_OK,      32'h8000_0000, 5'd2,  1'b0}},
        '{ACT_PUSH, -32'sd3,         1, 1'b1, '{ST_OK,      32'hffff_fffd, 5'd3,  1'b0}},
        '{ACT_PUSH, -32'sd4,         1, 1'b1, '{ST_OK,      32'hffff_fffc, 5'd4,  1'b0}},
        // -3 sits below the top: the gap closes under -4
        '{ACT_ODD,  32'sd0,          1, 1'b0, '0},
        // fill to the brim with 0 and all-ones
        '{ACT_PUSH, 32'sd0,          7, 1'b0, '0},
        '{ACT_PUSH, -32'sd1,         6, 1'b0, '0},
        '{ACT_PUSH, 32'sh5555_5555,  1, 1'b1, '{ST_FULL,    32'hffff_ffff, 5'd16, 1'b0}},
        // deep even hit on a full stack, then top pop and odd removal
        '{ACT_EVEN, 32'sd0,          1, 1'b0, '0},
        '{ACT_POP,  32'sd0,          1, 1'b0, '0},
        '{ACT_ODD,  32'sd0,          1, 1'b0, '0}
    };

    parity_select_stack_top #(
        .DEPTH      (STACK_DEPTH),
        .WORD_WIDTH (32)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_top_value (o_top_value),
        .o_count     (o_count),
        .o_is_empty  (o_is_empty)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Applies one operation to the shadow stack and returns what the block
    // should report for it.
    function automatic t_result stack_apply(t_action act, logic signed [31:0] val);
        t_result r;
        int      hit;
        r.status = ST_OK;
        hit      = -1;
        if (act == ACT_PUSH) begin
            if (shadow_fill == STACK_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                shadow_words[shadow_fill] = val;
                shadow_fill++;
            end
        end else if (shadow_fill == 0) begin
            r.status = ST_EMPTY;
        end else if (act == ACT_POP) begin
            shadow_fill--;
        end else begin
            // search downward from the top; parity is bit 0 of the pattern
            for (int i = shadow_fill - 1; i >= 0 && hit < 0; i--) begin
                if (shadow_words[i][0] == (act == ACT_ODD))
                    hit = i;
            end
            if (hit < 0) begin
                r.status = ST_NOMATCH;
            end else begin
                for (int j = hit; j < shadow_fill - 1; j++)
                    shadow_words[j] = shadow_words[j + 1];
                shadow_fill--;
            end
        end
        r.top_value = (shadow_fill != 0) ? shadow_words[shadow_fill - 1] : '0;
        r.count     = COUNT_WIDTH'(shadow_fill);
        r.is_empty  = (shadow_fill == 0);
        return r;
    endfunction

    // Offers one word and returns at the edge that takes it. A random gap may
    // come first, unless the run is in its calm tail.
    task automatic send_word(t_action act, logic signed [31:0] val, bit has_check,
                             t_result check);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_value        <= val;
        stim_has_check <= has_check;
        stim_check     <= check;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Monitor: predict on every accepted word, check on every accepted result.
    // Sampling at the edge sees the values from before it.
    always @(posedge i_clk) begin
        t_result predicted;
        t_result want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predicted = stack_apply(t_action'(i_action), i_value);
                pending_results.push_back(stim_has_check ? stim_check : predicted);
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result with nothing expected: status %0d, top %0d",
                           o_status, o_top_value);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        fail_count++;
                    end
                    if (o_top_value !== want.top_value) begin
                        $error("top_value: expected %0d, got %0d",
                               $signed(want.top_value), o_top_value);
                        fail_count++;
                    end
                    if (o_count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, o_count);
                        fail_count++;
                    end
                    if (o_is_empty !== want.is_empty) begin
                        $error("is_empty: expected %0d, got %0d", want.is_empty, o_is_empty);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Receiver: one long hold-off on request, else random stall and free runs.
    initial begin
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int                 sent;
        int                 run;
        int                 push_pct;
        bit                 fix_par;
        bit                 par;
        t_action            act;
        logic signed [31:0] val;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            for (int n = 0; n < directed_rows[r].reps; n++)
                send_word(directed_rows[r].act, directed_rows[r].val,
                          directed_rows[r].has_check, directed_rows[r].check);
        end

        // random episodes; the first word goes out under the long hold-off,
        // so the block backs up and stalls its input
        hold_req = 1'b1;
        sent     = 0;
        while (sent < RANDOM_ITEMS) begin
            run      = $urandom_range(8, 24);
            fix_par  = ($urandom_range(0, 2) == 0);   // starves one parity
            par      = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 2))
                0:       push_pct = 80;                 // climb towards full
                1:       push_pct = 25;                 // drain towards empty
                default: push_pct = 50;
            endcase
            for (int k = 0; k < run && sent < RANDOM_ITEMS; k++) begin
                if ($urandom_range(0, 99) < push_pct)
                    act = ACT_PUSH;
                else
                    act = t_action'($urandom_range(1, 3));
                case ($urandom_range(0, 7))
                    0:       val = 32'sd0;
                    1:       val = -32'sd1;
                    2:       val = 32'sh7fff_ffff;
                    3:       val = 32'sh8000_0000;
                    4:       val = $signed(32'($urandom_range(0, 15))) - 32'sd8;
                    default: val = $urandom;
                endcase
                if (fix_par)
                    val[0] = par;
                calm = (RANDOM_ITEMS - sent) <= CALM_ITEMS;
                send_word(act, val, 1'b0, '0);
                sent++;
            end
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
